// ===== design/hsd_pkg.sv =====
// Shared types and constants for the Huffman symbol decoder.
// Request/response words, item kind codes and the sequencer state type.
// No dependencies.
package hsd_pkg;

   localparam int KIND_W = 2;
   localparam int SYM_W  = 9;
   localparam int CODE_W = 15;
   localparam int LEN_W  = 4;
   localparam int WIN_W  = 15;

   localparam logic [SYM_W-1:0] SYMBOL_COUNT_RESET = 9'd288;

   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_LOAD   = 2'd1,
      KIND_DECODE = 2'd2
   } hsd_kind_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SYM_W-1:0]  symbol_index;
      logic [CODE_W-1:0] code_value;
      logic [LEN_W-1:0]  code_length;
      logic [WIN_W-1:0]  bit_window;
   } hsd_req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic [LEN_W-1:0] used_bits;
      logic             found;
   } hsd_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_FAST,
      ST_SCAN,
      ST_DONE
   } hsd_state_type;

endpackage

// ===== design/huffman_symbol_decoder.sv =====
// Huffman symbol decoder, top level. A decode reads the fast table and, on a hit, goes
// straight to the result; a fast miss scans the code list entry by entry (symbol_count
// entries, capped at SYMBOL_DEPTH). Load: writes the code list, then for a code of at
// most FAST_WIDTH bits 2^(FAST_WIDTH-len) fill writes, one per cycle on the fast-table port.
// Clear: sweeps max(2^FAST_WIDTH, SYMBOL_DEPTH) entries (512 at defaults). One item at a
// time. Synchronous reset runs the same clearing sweep over both tables before
// req_ready rises; csr writes are taken as ever.
module huffman_symbol_decoder #(
   parameter int FAST_WIDTH   = 9,
   parameter int MAX_CODE_LEN = 15,
   parameter int SYMBOL_DEPTH = 288
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  hsd_pkg::hsd_req_type      req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output hsd_pkg::hsd_rsp_type      rsp_data,
   input  logic                      csr_wr_en,
   input  logic [hsd_pkg::SYM_W-1:0] csr_wr_data
);
   import hsd_pkg::*;

   localparam int FAST_SLOTS = 1 << FAST_WIDTH;
   localparam int IDX_W      = $clog2(SYMBOL_DEPTH);
   localparam int LIM_W      = IDX_W + 1;
   localparam int SLOT_W     = FAST_WIDTH + 1;
   localparam int CLR_N      = (FAST_SLOTS > SYMBOL_DEPTH) ? FAST_SLOTS : SYMBOL_DEPTH;
   localparam int CLR_W      = $clog2(CLR_N);
   localparam int LIST_W     = CODE_W + LEN_W;
   localparam int FENT_W     = SYM_W + LEN_W;

   // sequencer and control
   hsd_state_type     state_ff, state_in;
   logic [CLR_W-1:0]  sweep_ff, sweep_in;
   logic [SYM_W-1:0]  csr_count_ff;

   // latched item fields
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [WIN_W-1:0]  window_ff, window_in;

   // fill and scan counters
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // best match so far
   logic [SYM_W-1:0]  best_sym_ff, best_sym_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   logic              best_found_ff, best_found_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   hsd_rsp_type       rsp_data_ff, rsp_data_in;

   // memories
   logic [LIST_W-1:0] list_mem [SYMBOL_DEPTH];
   logic [FENT_W-1:0] fast_mem [FAST_SLOTS];
   logic [LIST_W-1:0] list_rd_ff;
   logic [FENT_W-1:0] fast_rd_ff;

   logic                  list_we, fast_we;
   logic [IDX_W-1:0]      list_wa, list_ra;
   logic [LIST_W-1:0]     list_wd;
   logic [FAST_WIDTH-1:0] fast_wa, fast_ra;
   logic [FENT_W-1:0]     fast_wd;

   // shared prefix unit
   logic [WIN_W-1:0] pu_value, pu_prefix;
   logic [LEN_W-1:0] pu_len;

   logic [CODE_W-1:0] rd_code;
   logic [LEN_W-1:0]  rd_len, f_len;
   logic [SYM_W-1:0]  f_sym;
   logic [LIM_W-1:0]  limit;
   logic [SLOT_W-1:0] step;
   logic req_accept, load_ok, fill_ok, fast_hit, match, better;
   logic scan_last, sweep_last, rsp_free;

   hsd_prefix_unit u_prefix (
      .value  (pu_value),
      .len    (pu_len),
      .prefix (pu_prefix)
   );

   // decoded fields and conditions
   assign rd_code    = list_rd_ff[LIST_W-1:LEN_W];
   assign rd_len     = list_rd_ff[LEN_W-1:0];
   assign f_sym      = fast_rd_ff[FENT_W-1:LEN_W];
   assign f_len      = fast_rd_ff[LEN_W-1:0];
   assign fast_hit   = (f_len != '0) && (int'(f_len) <= FAST_WIDTH);
   assign match      = (rd_len != '0) && (int'(rd_len) <= MAX_CODE_LEN)
                       && (rd_code == pu_prefix);
   assign better     = match && (!best_found_ff || (rd_len < best_len_ff));
   assign limit      = (int'(csr_count_ff) > SYMBOL_DEPTH) ? LIM_W'(SYMBOL_DEPTH)
                                                          : LIM_W'(csr_count_ff);
   assign scan_last  = (LIM_W'(idx_ff) + LIM_W'(1)) == limit;
   assign sweep_last = sweep_ff == CLR_W'(CLR_N - 1);
   assign step       = SLOT_W'(1) << len_ff;
   assign req_ready  = state_ff == ST_IDLE;
   assign req_accept = req_valid && req_ready;
   assign load_ok    = int'(req_data.symbol_index) < SYMBOL_DEPTH;
   assign fill_ok    = (req_data.code_length != '0)
                       && (int'(req_data.code_length) <= FAST_WIDTH);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (sweep_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.kind)
                  KIND_CLEAR:  state_in = ST_CLEAR;
                  KIND_LOAD:   if (load_ok && fill_ok) state_in = ST_FILL;
                  KIND_DECODE: state_in = ST_FAST;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: if (slot_in[FAST_WIDTH]) state_in = ST_IDLE;
         ST_FAST: begin
            if (fast_hit || (limit == '0)) state_in = ST_DONE;
            else state_in = ST_SCAN;
         end
         ST_SCAN: if (scan_last) state_in = ST_DONE;
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      sweep_in      = sweep_ff;
      sym_in        = sym_ff;
      len_in        = len_ff;
      window_in     = window_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      best_sym_in   = best_sym_ff;
      best_len_in   = best_len_ff;
      best_found_in = best_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      list_we       = 1'b0;
      list_wa       = '0;
      list_wd       = '0;
      list_ra       = '0;
      fast_we       = 1'b0;
      fast_wa       = '0;
      fast_wd       = '0;
      fast_ra       = req_data.bit_window[FAST_WIDTH-1:0];
      pu_value      = window_ff;
      pu_len        = rd_len;
      case (state_ff)
         // zero both tables, one entry per cycle
         ST_CLEAR: begin
            list_we  = int'(sweep_ff) < SYMBOL_DEPTH;
            list_wa  = sweep_ff[IDX_W-1:0];
            fast_we  = int'(sweep_ff) < FAST_SLOTS;
            fast_wa  = sweep_ff[FAST_WIDTH-1:0];
            sweep_in = sweep_last ? '0 : sweep_ff + CLR_W'(1);
         end
         // take a word; a load with an in-range index writes the code list right away
         ST_IDLE: begin
            pu_value = req_data.code_value;
            pu_len   = req_data.code_length;
            if (req_accept) begin
               sym_in    = req_data.symbol_index;
               len_in    = req_data.code_length;
               window_in = req_data.bit_window;
               slot_in   = SLOT_W'(pu_prefix[FAST_WIDTH-1:0]);
               sweep_in  = '0;
               if ((req_data.kind == KIND_LOAD) && load_ok) begin
                  list_we = 1'b1;
                  list_wa = IDX_W'(req_data.symbol_index);
                  list_wd = {req_data.code_value, req_data.code_length};
               end
            end
         end
         // replicate the entry into every slot sharing its low bits
         ST_FILL: begin
            fast_we = 1'b1;
            fast_wa = slot_ff[FAST_WIDTH-1:0];
            fast_wd = {sym_ff, len_ff};
            slot_in = slot_ff + step;
         end
         // fast-table data is in; start the list scan at entry 0
         ST_FAST: begin
            idx_in = '0;
            if (fast_hit) begin
               best_sym_in   = f_sym;
               best_len_in   = f_len;
               best_found_in = 1'b1;
            end else begin
               best_sym_in   = '0;
               best_len_in   = '0;
               best_found_in = 1'b0;
            end
         end
         // one entry per cycle; shortest code wins, lowest index on ties
         ST_SCAN: begin
            list_ra = scan_last ? '0 : idx_ff + IDX_W'(1);
            idx_in  = idx_ff + IDX_W'(1);
            if (better) begin
               best_sym_in   = SYM_W'(idx_ff);
               best_len_in   = rd_len;
               best_found_in = 1'b1;
            end
         end
         // hand the result to the output register when it is free
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{symbol: best_sym_ff, used_bits: best_len_ff,
                                found: best_found_ff};
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // symbol count register
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_count_ff <= SYMBOL_COUNT_RESET;
      end else if (csr_wr_en) begin
         csr_count_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      len_ff        <= len_in;
      window_ff     <= window_in;
      slot_ff       <= slot_in;
      idx_ff        <= idx_in;
      best_sym_ff   <= best_sym_in;
      best_len_ff   <= best_len_in;
      best_found_ff <= best_found_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // code list memory
   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_wa] <= list_wd;
      end
      list_rd_ff <= list_mem[list_ra];
   end

   // fast table memory
   always_ff @(posedge clock) begin
      if (fast_we) begin
         fast_mem[fast_wa] <= fast_wd;
      end
      fast_rd_ff <= fast_mem[fast_ra];
   end

endmodule

// ===== design/hsd_prefix_unit.sv =====
// Shared bit-reverse and shift unit: first len bits of a stream word, MSB-first.
// Used for fast-table slot generation and for slow-path code compares.
// Depends on hsd_pkg.
module hsd_prefix_unit (
   input  logic [hsd_pkg::WIN_W-1:0] value,
   input  logic [hsd_pkg::LEN_W-1:0] len,
   output logic [hsd_pkg::WIN_W-1:0] prefix
);
   import hsd_pkg::*;

   logic [WIN_W-1:0] mirrored;
   logic [LEN_W:0]   shift_amt;

   // mirror the whole word: stream bit 0 lands in the MSB
   always_comb begin
      for (int k = 0; k < WIN_W; k++) begin
         mirrored[WIN_W-1-k] = value[k];
      end
   end

   // keep only the top len bits, right aligned
   assign shift_amt = (LEN_W+1)'(WIN_W) - {1'b0, len};
   assign prefix    = mirrored >> shift_amt;

endmodule

// ===== design/hsd_checker.sv =====
// Port-level checks for the Huffman symbol decoder, bound to the top level.
// Depends on hsd_pkg and huffman_symbol_decoder.
module hsd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input hsd_pkg::hsd_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input hsd_pkg::hsd_rsp_type rsp_data
);
   import hsd_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp word changed");

   // a miss reports zero symbol and zero length
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.symbol == '0 && rsp_data.used_bits == '0)
      else $error("miss with nonzero fields");

   // a hit always consumes bits
   a_hit_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.used_bits != '0)
      else $error("hit with zero length");

   // a decode word keeps the block busy for the next cycle
   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_DECODE |=> !req_ready)
      else $error("ready right after decode accept");

   // a new result only follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while idle");

endmodule

bind huffman_symbol_decoder hsd_checker u_hsd_checker (.*);
